// ===== design/hph_pkg.sv =====
// Shared types, state codes and character classes for the HTTP request header parser.
// No dependencies; imported by hph_step and http_request_header_parser.
`default_nettype none

package hph_pkg;

  // Parse state codes
  localparam logic [4:0] S_MSTART = 5'd0;
  localparam logic [4:0] S_METH   = 5'd1;
  localparam logic [4:0] S_URI    = 5'd2;
  localparam logic [4:0] S_H      = 5'd3;
  localparam logic [4:0] S_T1     = 5'd4;
  localparam logic [4:0] S_T2     = 5'd5;
  localparam logic [4:0] S_P      = 5'd6;
  localparam logic [4:0] S_SLASH  = 5'd7;
  localparam logic [4:0] S_MAJ0   = 5'd8;
  localparam logic [4:0] S_MAJ    = 5'd9;
  localparam logic [4:0] S_MIN0   = 5'd10;
  localparam logic [4:0] S_MIN    = 5'd11;
  localparam logic [4:0] S_NL1    = 5'd12;
  localparam logic [4:0] S_LINE   = 5'd13;
  localparam logic [4:0] S_LWS    = 5'd14;
  localparam logic [4:0] S_NAME   = 5'd15;
  localparam logic [4:0] S_SPACE  = 5'd16;
  localparam logic [4:0] S_VALUE  = 5'd17;
  localparam logic [4:0] S_NL2    = 5'd18;
  localparam logic [4:0] S_NL3    = 5'd19;

  // Status codes
  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Byte roles
  localparam logic [2:0] ROLE_DELIM  = 3'd0;
  localparam logic [2:0] ROLE_METHOD = 3'd1;
  localparam logic [2:0] ROLE_URI    = 3'd2;
  localparam logic [2:0] ROLE_HNEW   = 3'd3;
  localparam logic [2:0] ROLE_HNAME  = 3'd4;
  localparam logic [2:0] ROLE_HVALUE = 3'd5;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CTLMX = 8'h1F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_UP_T  = 8'h54;
  localparam logic [7:0] CH_UP_P  = 8'h50;

  localparam logic [15:0] VER_MAX = 16'hFFFF;
  localparam logic [7:0]  HDR_MAX = 8'hFF;

  // Parser context carried from byte to byte
  typedef struct packed {
    logic [4:0]  state;
    logic [15:0] major;
    logic [15:0] minor;
    logic [7:0]  hdr;
  } ctx_t;

  // Per-byte verdict
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] role;
  } verdict_t;

  localparam ctx_t CTX_RESET = '{state: S_MSTART, major: 16'd0, minor: 16'd0, hdr: 8'd0};

  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= CH_CTLMX) || (c == CH_DEL);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    logic r;
    r = 1'b0;
    unique case (c)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // High-half bytes act as negative chars: never tokens
  function automatic logic is_token(input logic [7:0] c);
    return !c[7] && !is_ctl(c) && !is_sep(c);
  endfunction

  function automatic logic is_dec_char(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // v*10 + digit, saturating at 16 bits
  function automatic logic [15:0] dec_push(input logic [15:0] v, input logic [7:0] c);
    logic [19:0] sum;
    logic [7:0]  dig;
    dig = c - CH_ZERO;
    sum = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {12'd0, dig};
    return (sum[19:16] != 4'd0) ? VER_MAX : sum[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/hph_step.sv =====
// Next-state and verdict logic for one request byte of the header parser.
// Depends on hph_pkg.
`default_nettype none

module hph_step (
  input  hph_pkg::ctx_t     cur_i,
  input  logic              restart_i,
  input  logic [7:0]        byte_i,
  output hph_pkg::ctx_t     nxt_o,
  output hph_pkg::verdict_t vrd_o
);
  import hph_pkg::*;

  ctx_t c;
  logic ws;

  assign c  = restart_i ? CTX_RESET : cur_i;
  assign ws = (byte_i == CH_SP) || (byte_i == CH_HT);

  always_comb begin
    nxt_o = c;
    vrd_o = '{status: ST_MORE, role: ROLE_DELIM};
    unique case (c.state)
      S_MSTART: begin
        if (is_token(byte_i)) begin
          nxt_o.state = S_METH;
          vrd_o.role  = ROLE_METHOD;
        end else vrd_o.status = ST_BAD;
      end
      S_METH: begin
        if (byte_i == CH_SP) nxt_o.state = S_URI;
        else if (is_token(byte_i)) vrd_o.role = ROLE_METHOD;
        else vrd_o.status = ST_BAD;
      end
      S_URI: begin
        if (byte_i == CH_SP) nxt_o.state = S_H;
        else if (is_ctl(byte_i)) vrd_o.status = ST_BAD;
        else vrd_o.role = ROLE_URI;
      end
      S_H: begin
        if (byte_i == CH_UP_H) nxt_o.state = S_T1;
        else vrd_o.status = ST_BAD;
      end
      S_T1: begin
        if (byte_i == CH_UP_T) nxt_o.state = S_T2;
        else vrd_o.status = ST_BAD;
      end
      S_T2: begin
        if (byte_i == CH_UP_T) nxt_o.state = S_P;
        else vrd_o.status = ST_BAD;
      end
      S_P: begin
        if (byte_i == CH_UP_P) nxt_o.state = S_SLASH;
        else vrd_o.status = ST_BAD;
      end
      S_SLASH: begin
        if (byte_i == CH_SLASH) begin
          nxt_o.major = 16'd0;
          nxt_o.minor = 16'd0;
          nxt_o.state = S_MAJ0;
        end else vrd_o.status = ST_BAD;
      end
      S_MAJ0: begin
        if (is_dec_char(byte_i)) begin
          nxt_o.major = dec_push(c.major, byte_i);
          nxt_o.state = S_MAJ;
        end else vrd_o.status = ST_BAD;
      end
      S_MAJ: begin
        if (byte_i == CH_DOT) nxt_o.state = S_MIN0;
        else if (is_dec_char(byte_i)) nxt_o.major = dec_push(c.major, byte_i);
        else vrd_o.status = ST_BAD;
      end
      S_MIN0: begin
        if (is_dec_char(byte_i)) begin
          nxt_o.minor = dec_push(c.minor, byte_i);
          nxt_o.state = S_MIN;
        end else vrd_o.status = ST_BAD;
      end
      S_MIN: begin
        if (byte_i == CH_CR) nxt_o.state = S_NL1;
        else if (is_dec_char(byte_i)) nxt_o.minor = dec_push(c.minor, byte_i);
        else vrd_o.status = ST_BAD;
      end
      S_NL1: begin
        if (byte_i == CH_LF) nxt_o.state = S_LINE;
        else vrd_o.status = ST_BAD;
      end
      S_LINE: begin
        // continuation line only legal once a header has been seen
        if (byte_i == CH_CR) nxt_o.state = S_NL3;
        else if ((c.hdr != 8'd0) && ws) nxt_o.state = S_LWS;
        else if (is_token(byte_i)) begin
          if (c.hdr != HDR_MAX) nxt_o.hdr = c.hdr + 8'd1;
          nxt_o.state = S_NAME;
          vrd_o.role  = ROLE_HNEW;
        end else vrd_o.status = ST_BAD;
      end
      S_LWS: begin
        if (byte_i == CH_CR) nxt_o.state = S_NL2;
        else if (ws) nxt_o.state = S_LWS;
        else if (is_ctl(byte_i)) vrd_o.status = ST_BAD;
        else begin
          nxt_o.state = S_VALUE;
          vrd_o.role  = ROLE_HVALUE;
        end
      end
      S_NAME: begin
        if (byte_i == CH_COLON) nxt_o.state = S_SPACE;
        else if (is_token(byte_i)) vrd_o.role = ROLE_HNAME;
        else vrd_o.status = ST_BAD;
      end
      S_SPACE: begin
        if (byte_i == CH_SP) nxt_o.state = S_VALUE;
        else vrd_o.status = ST_BAD;
      end
      S_VALUE: begin
        if (byte_i == CH_CR) nxt_o.state = S_NL2;
        else if (is_ctl(byte_i)) vrd_o.status = ST_BAD;
        else vrd_o.role = ROLE_HVALUE;
      end
      S_NL2: begin
        if (byte_i == CH_LF) nxt_o.state = S_LINE;
        else vrd_o.status = ST_BAD;
      end
      S_NL3: begin
        vrd_o.status = (byte_i == CH_LF) ? ST_DONE : ST_BAD;
      end
      default: begin
        vrd_o.status = ST_BAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/http_request_header_parser.sv =====
// HTTP request line and header parser, one request byte per cycle while the output is not stalled.
// Results are registered: a result appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle when the output is not stalled; the parse context is registered per accepted byte.
// Input is taken whenever the result register is empty or being drained.
// Reset (rst_ni low, async) returns to method start with counters cleared and
// drops any pending result.
// Depends on hph_pkg and hph_step.
`default_nettype none

module http_request_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [1:0] status, [9:2] out_byte, [25:10] version_major,
                                      // [41:26] version_minor, [49:42] header_count, [55:50] 0
  output logic [2:0]  m_axis_tuser    // [2:0] byte_role
);
  import hph_pkg::*;

  ctx_t       ctx_q, ctx_d;
  verdict_t   vrd_d;
  logic       vld_q;
  logic [1:0] status_q;
  logic [2:0] role_q;
  logic [7:0] byte_q;
  logic       in_acc;

  assign s_axis_tready = !vld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  hph_step u_step (
    .cur_i     (ctx_q),
    .restart_i (s_axis_tuser),
    .byte_i    (s_axis_tdata),
    .nxt_o     (ctx_d),
    .vrd_o     (vrd_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= CTX_RESET;
      vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        ctx_q <= ctx_d;
        vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= vrd_d.status;
      role_q   <= vrd_d.role;
      byte_q   <= s_axis_tdata;
    end
  end

  // counters shown are the context after the byte, which holds until the next byte is accepted
  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = role_q;
  assign m_axis_tdata  = {6'd0, ctx_q.hdr, ctx_q.minor, ctx_q.major, byte_q, status_q};

  // Assertions
  a_done_in_nl3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && (status_q == ST_DONE) |-> ctx_q.state == S_NL3)
    else $error("complete status outside final-newline state");

  a_role_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && (role_q != ROLE_DELIM) |-> status_q == ST_MORE)
    else $error("byte role reported with non-more status");

  a_bad_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tuser && (vrd_d.status == ST_BAD) |=> $stable(ctx_q))
    else $error("invalid byte changed parse context");

  a_hdr_first_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (vrd_d.role == ROLE_HNEW) |=> ctx_q.state == S_NAME && ctx_q.hdr != 8'd0)
    else $error("new header did not enter name state");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for http_request_header_parser: byte streams in, one verdict per byte.
// Expected verdicts come from a parser model in the scoreboard class; uses hph_pkg.
// Depends on design/hph_pkg.sv and design/http_request_header_parser.sv.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hph_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int RESET_CYCLES = 12;
  localparam int PHASE_ITEMS = 80;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } req_byte_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  role;
    logic [7:0]  data;
    logic [15:0] major;
    logic [15:0] minor;
    logic [7:0]  hdrs;
  } byte_verdict_t;

  // Parser model plus the FIFO of verdicts still owed by the block
  class header_parse_board;
    logic [4:0]    pstate;
    logic [15:0]   maj_count;
    logic [15:0]   min_count;
    logic [7:0]    hdr_total;
    byte_verdict_t expected_verdicts[$];
    int            mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      pstate    = S_MSTART;
      maj_count = '0;
      min_count = '0;
      hdr_total = '0;
    endfunction

    static function bit ctrl_char(logic [7:0] c);
      return c <= CH_CTLMX || c == CH_DEL;
    endfunction

    static function bit separator_char(logic [7:0] c);
      case (c)
        "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
        "/", "[", "]", "?", "=", "{", "}", CH_SP, CH_HT: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // bytes 128..255 are negative chars on the original target: never tokens
    static function bit token_char(logic [7:0] c);
      return !c[7] && !ctrl_char(c) && !separator_char(c);
    endfunction

    static function bit digit_char(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    static function logic [15:0] push_digit(logic [15:0] v, logic [7:0] c);
      int unsigned sum;
      sum = v * 10 + (c - CH_ZERO);
      return (sum > 32'(VER_MAX)) ? VER_MAX : sum[15:0];
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    function void note_request_byte(logic restart, logic [7:0] c);
      byte_verdict_t r;
      r.status = ST_MORE;
      r.role   = ROLE_DELIM;
      r.data   = c;
      if (restart) clear();
      case (pstate)
        S_MSTART: begin
          if (token_char(c)) begin
            pstate = S_METH;
            r.role = ROLE_METHOD;
          end else r.status = ST_BAD;
        end
        S_METH: begin
          if (c == CH_SP) pstate = S_URI;
          else if (token_char(c)) r.role = ROLE_METHOD;
          else r.status = ST_BAD;
        end
        S_URI: begin
          if (c == CH_SP) pstate = S_H;
          else if (ctrl_char(c)) r.status = ST_BAD;
          else r.role = ROLE_URI;
        end
        S_H:     if (c == CH_UP_H) pstate = S_T1; else r.status = ST_BAD;
        S_T1:    if (c == CH_UP_T) pstate = S_T2; else r.status = ST_BAD;
        S_T2:    if (c == CH_UP_T) pstate = S_P; else r.status = ST_BAD;
        S_P:     if (c == CH_UP_P) pstate = S_SLASH; else r.status = ST_BAD;
        S_SLASH: begin
          if (c == CH_SLASH) begin
            maj_count = '0;
            min_count = '0;
            pstate    = S_MAJ0;
          end else r.status = ST_BAD;
        end
        S_MAJ0: begin
          if (digit_char(c)) begin
            maj_count = push_digit(maj_count, c);
            pstate    = S_MAJ;
          end else r.status = ST_BAD;
        end
        S_MAJ: begin
          if (c == CH_DOT) pstate = S_MIN0;
          else if (digit_char(c)) maj_count = push_digit(maj_count, c);
          else r.status = ST_BAD;
        end
        S_MIN0: begin
          if (digit_char(c)) begin
            min_count = push_digit(min_count, c);
            pstate    = S_MIN;
          end else r.status = ST_BAD;
        end
        S_MIN: begin
          if (c == CH_CR) pstate = S_NL1;
          else if (digit_char(c)) min_count = push_digit(min_count, c);
          else r.status = ST_BAD;
        end
        S_NL1: if (c == CH_LF) pstate = S_LINE; else r.status = ST_BAD;
        S_LINE: begin
          if (c == CH_CR) pstate = S_NL3;
          else if (hdr_total != 0 && (c == CH_SP || c == CH_HT)) pstate = S_LWS;
          else if (token_char(c)) begin
            if (hdr_total != HDR_MAX) hdr_total = hdr_total + 8'd1;
            pstate = S_NAME;
            r.role = ROLE_HNEW;
          end else r.status = ST_BAD;
        end
        S_LWS: begin
          if (c == CH_CR) pstate = S_NL2;
          else if (c == CH_SP || c == CH_HT) pstate = S_LWS;
          else if (ctrl_char(c)) r.status = ST_BAD;
          else begin
            pstate = S_VALUE;
            r.role = ROLE_HVALUE;
          end
        end
        S_NAME: begin
          if (c == CH_COLON) pstate = S_SPACE;
          else if (token_char(c)) r.role = ROLE_HNAME;
          else r.status = ST_BAD;
        end
        S_SPACE: if (c == CH_SP) pstate = S_VALUE; else r.status = ST_BAD;
        S_VALUE: begin
          if (c == CH_CR) pstate = S_NL2;
          else if (ctrl_char(c)) r.status = ST_BAD;
          else r.role = ROLE_HVALUE;
        end
        S_NL2: if (c == CH_LF) pstate = S_LINE; else r.status = ST_BAD;
        // request done; state sticks here until restart
        S_NL3: r.status = (c == CH_LF) ? ST_DONE : ST_BAD;
        default: r.status = ST_BAD;
      endcase
      r.major = maj_count;
      r.minor = min_count;
      r.hdrs  = hdr_total;
      expected_verdicts.insert(expected_verdicts.size(), r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_verdict(byte_verdict_t got);
      byte_verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $error("verdict received with no request byte outstanding");
        mismatches++;
        return;
      end
      want = expected_verdicts.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("byte_role", 16'(want.role), 16'(got.role));
      compare_field("out_byte", 16'(want.data), 16'(got.data));
      compare_field("version_major", want.major, got.major);
      compare_field("version_minor", want.minor, got.minor);
      compare_field("header_count", 16'(want.hdrs), 16'(got.hdrs));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  header_parse_board board = new();
  req_byte_t         stim_q[$];
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int                cycles = 0;

  http_request_header_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : result_monitor
    byte_verdict_t seen;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.status = m_axis_tdata[1:0];
      seen.role   = m_axis_tuser;
      seen.data   = m_axis_tdata[9:2];
      seen.major  = m_axis_tdata[25:10];
      seen.minor  = m_axis_tdata[41:26];
      seen.hdrs   = m_axis_tdata[49:42];
      board.check_verdict(seen);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("http_request_header_parser test failed");
      $finish;
    end
  end

  // ---- stimulus generation ----

  function automatic void put(logic restart, logic [7:0] data);
    req_byte_t b;
    b.restart = restart;
    b.data    = data;
    stim_q.insert(stim_q.size(), b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put(1'b0, s[i]);
  endfunction

  function automatic void put_crlf();
    put(1'b0, CH_CR);
    put(1'b0, CH_LF);
  endfunction

  function automatic logic [7:0] rand_token();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    while (!header_parse_board::token_char(c)) c = 8'($urandom_range(33, 126));
    return c;
  endfunction

  // any byte but control chars; the URI also excludes space
  function automatic logic [7:0] rand_text(bit allow_space);
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (header_parse_board::ctrl_char(c) || (!allow_space && c == CH_SP))
      c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic void put_digits();
    int n;
    n = ($urandom_range(99) < 15) ? $urandom_range(5, 7) : $urandom_range(1, 2);
    repeat (n) put(1'b0, CH_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic void put_noise();
    repeat ($urandom_range(1, 6)) put($urandom_range(3) == 0, 8'($urandom_range(255)));
  endfunction

  // Well-formed request with random content; sometimes one byte corrupted
  // or junk appended after the terminating empty line.
  function automatic void build_request(int min_headers);
    int        first;
    int        pos;
    req_byte_t hit;
    first = stim_q.size();
    put($urandom_range(99) >= 5, rand_token());
    repeat ($urandom_range(0, 5)) put(1'b0, rand_token());
    put(1'b0, CH_SP);
    repeat ($urandom_range(1, 8)) put(1'b0, rand_text(1'b0));
    put(1'b0, CH_SP);
    put_text("HTTP/");
    put_digits();
    put(1'b0, CH_DOT);
    put_digits();
    put_crlf();
    repeat (min_headers + $urandom_range(0, 4)) begin
      repeat ($urandom_range(1, 6)) put(1'b0, rand_token());
      put(1'b0, CH_COLON);
      put(1'b0, CH_SP);
      repeat ($urandom_range(0, 8)) put(1'b0, rand_text(1'b1));
      put_crlf();
      if ($urandom_range(99) < 25) begin
        repeat ($urandom_range(1, 2)) put(1'b0, $urandom_range(1) ? CH_SP : CH_HT);
        repeat ($urandom_range(0, 6)) put(1'b0, rand_text(1'b1));
        put_crlf();
      end
    end
    put_crlf();
    if (min_headers == 0 && $urandom_range(99) < 20) begin
      pos = $urandom_range(first, stim_q.size() - 1);
      hit = stim_q[pos];
      hit.data = 8'($urandom_range(255));
      stim_q[pos] = hit;
    end
    if ($urandom_range(99) < 10) repeat ($urandom_range(1, 3)) put(1'b0, 8'($urandom_range(255)));
  endfunction

  // shortest header lines, enough of them to saturate the header count
  function automatic void build_header_flood();
    put(1'b1, rand_token());
    put_text(" / HTTP/1.1");
    put_crlf();
    repeat (257) begin
      put(1'b0, rand_token());
      put(1'b0, CH_COLON);
      put(1'b0, CH_SP);
      put_crlf();
    end
    put_crlf();
  endfunction

  // ---- driving ----

  task automatic send_byte(req_byte_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b.data;
    s_axis_tuser  <= b.restart;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request_byte(b.restart, b.data);
  endtask

  // send everything queued, then hold off until every verdict is back
  task automatic send_all();
    while (stim_q.size() != 0) send_byte(stim_q.pop_front());
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int idle_pct, int stall, bit with_flood);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    while (stim_q.size() < PHASE_ITEMS) begin
      if ($urandom_range(99) < 8) put_noise();
      else build_request(0);
    end
    if (with_flood) build_header_flood();
    send_all();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: high bytes, control chars, early continuation, sticky done state
    put(1'b1, 8'hFF);
    put_text("G ");
    put(1'b0, 8'h80);
    put(1'b0, CH_DEL);
    put_text(" HTTP/9.0");
    put_crlf();
    put(1'b0, CH_SP);
    put_text("A: ");
    put(1'b0, 8'hFF);
    put_crlf();
    put(1'b0, CH_HT);
    put_crlf();
    put_crlf();
    put(1'b0, CH_LF);
    put(1'b0, "x");
    put(1'b1, 8'h00);
    send_all();

    run_phase(0, 0, 1'b1);
    run_phase(82, 0, 1'b0);
    run_phase(0, 82, 1'b0);
    run_phase(14, 14, 1'b0);

    repeat (4) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("http_request_header_parser test passed");
    end else begin
      $display("http_request_header_parser test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/hph_pkg.sv
design/hph_step.sv
design/http_request_header_parser.sv
verif/testbench.sv
